>>> src/dfus_pkg.sv
// Shared constants and control types for the DMX universe splitter.
`timescale 1ns / 1ps
`default_nettype none
package dfus_pkg;

    // Parameter defaults.
    localparam int MAX_UNIVERSES_DEF = 64;
    localparam int MAX_PIXELS_DEF    = 65536;

    // Fixed geometry of a DMX universe and of one fixture.
    localparam int UNIVERSE_BYTES = 512;
    localparam int MAX_RUNS       = 9;
    localparam int RUN_IDX_W      = $clog2(MAX_RUNS);

    // Field widths.
    localparam int ID_W    = 15;
    localparam int ADDR_W  = 9;
    localparam int PCNT_W  = 10;
    localparam int CPP_W   = 3;
    localparam int SLOTO_W = 6;
    localparam int RUNB_W  = 10;
    localparam int FPIX_W  = 16;
    localparam int PBYTE_W = 2;
    localparam int TOTAL_W = 12;

    // Input mode codes.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_MAP    = 2'd2;

    // Commands from the sequencer to the patch table.
    typedef struct packed {
        logic clear;
        logic append;
        logic scan;
    } t_tbl_cmd;

    // Status of the patch table scan, one entry compared per cycle.
    typedef struct packed {
        logic                 busy;
        logic                 hit;
        logic [RUN_IDX_W-1:0] run_idx;
    } t_tbl_stat;

endpackage
`default_nettype wire

>>> src/dmx_fixture_universe_splitter_unit.sv
// Top level of the DMX universe splitter: sequencer, run planner and output register.
//
// Input channel i_valid/o_ready carries one command per transfer: clear the
// patch table and pixel index, append a universe id, or map one fixture.
// Output channel o_valid/i_ready carries copy instructions, one per run of the
// fixture's bytes that lands in a patched universe; o_last marks the final one.
// Clear and append complete at once and the block stays ready.
// A fixture first scans the patch table, one entry per cycle from the newest
// slot down through the single id comparator. It then plans one run per cycle
// while the output register is free, up to nine, plus a closing step.
// The output register holds an instruction while the receiver stalls and run
// planning pauses until it is taken; new commands are accepted only after the
// closing step, while the last instruction may still wait in the register.
// Reset empties the table, zeroes the pixel index and drops any pending output.
`timescale 1ns / 1ps
`default_nettype none
module dmx_fixture_universe_splitter_unit
    import dfus_pkg::*;
#(
    parameter int MAX_UNIVERSES = MAX_UNIVERSES_DEF,
    parameter int MAX_PIXELS    = MAX_PIXELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic [ID_W-1:0]    i_universe_id,
    input  wire logic [ADDR_W-1:0]  i_start_address,
    input  wire logic [PCNT_W-1:0]  i_pixel_count,
    input  wire logic [CPP_W-1:0]   i_channels_per_pixel,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [SLOTO_W-1:0]      o_universe_slot,
    output logic [ADDR_W-1:0]       o_universe_offset,
    output logic [RUNB_W-1:0]       o_run_bytes,
    output logic [CPP_W-1:0]        o_bytes_per_pixel,
    output logic [FPIX_W-1:0]       o_first_pixel,
    output logic [PBYTE_W-1:0]      o_first_pixel_byte,
    output logic                    o_last
);

    localparam int SLOT_W  = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
    localparam int PIX_CAP = (MAX_PIXELS - 1 > 65535) ? 65535 : MAX_PIXELS - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic [FPIX_W-1:0]    r_pix_base;
    logic [ID_W-1:0]      r_uid;
    logic [ADDR_W-1:0]    r_off;
    logic [TOTAL_W-1:0]   r_rem;
    logic [PBYTE_W-1:0]   r_pbyte;
    logic [TOTAL_W-1:0]   r_pix;
    logic [CPP_W-1:0]     r_cpp;
    logic [PCNT_W-1:0]    r_pcount;
    logic [RUN_IDX_W-1:0] r_k;
    logic [RUN_IDX_W-1:0] r_nruns;
    logic [MAX_RUNS-1:0]  r_found;
    logic [SLOT_W-1:0]    r_slot [MAX_RUNS];

    logic                 r_out_vld;
    logic [SLOTO_W-1:0]   r_o_slot;
    logic [ADDR_W-1:0]    r_o_off;
    logic [RUNB_W-1:0]    r_o_run;
    logic [CPP_W-1:0]     r_o_cpp;
    logic [FPIX_W-1:0]    r_o_pix;
    logic [PBYTE_W-1:0]   r_o_pbyte;
    logic                 r_o_last;

    logic                 accept;
    logic [CPP_W-1:0]     cpp_eff;
    logic [TOTAL_W-1:0]   total;
    t_tbl_cmd             tbl_cmd;
    t_tbl_stat            tbl_stat;
    logic [SLOT_W-1:0]    tbl_slot;
    logic [RUNB_W-1:0]    run_len;
    logic [TOTAL_W-1:0]   rem_next;
    logic [RUNB_W-1:0]    pix_inc;
    logic [PBYTE_W-1:0]   pbyte_next;
    logic                 out_free;
    logic                 emit;
    logic [MAX_RUNS-1:0]  run_mask;
    logic                 run_last;
    logic [13:0]          end_pos;
    logic [16:0]          pix_sum;
    logic [FPIX_W-1:0]    pix_sat;
    logic [16:0]          base_sum;
    logic [FPIX_W-1:0]    base_sat;
    logic [SLOT_W+SLOTO_W-1:0] slot_ext;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // Effective channels per pixel and byte count of the fixture.
    always_comb begin
        if (i_channels_per_pixel == '0) begin
            cpp_eff = CPP_W'(1);
        end else if (i_channels_per_pixel > CPP_W'(4)) begin
            cpp_eff = CPP_W'(4);
        end else begin
            cpp_eff = i_channels_per_pixel;
        end
        total = TOTAL_W'(i_pixel_count) * TOTAL_W'(cpp_eff);
    end

    // Table commands issue on the accepting edge.
    always_comb begin
        tbl_cmd.clear  = accept && (i_mode == MODE_CLEAR);
        tbl_cmd.append = accept && (i_mode == MODE_APPEND);
        tbl_cmd.scan   = accept && (i_mode == MODE_MAP);
    end

    dfus_table #(
        .MAX_UNIVERSES (MAX_UNIVERSES),
        .SLOT_W        (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (tbl_cmd),
        .i_id      (i_universe_id),
        .i_base_id (r_uid),
        .o_stat    (tbl_stat),
        .o_slot    (tbl_slot)
    );

    dfus_run u_run (
        .i_off     (r_off),
        .i_rem     (r_rem),
        .i_pbyte   (r_pbyte),
        .i_cpp     (r_cpp),
        .o_run     (run_len),
        .o_rem     (rem_next),
        .o_pix_inc (pix_inc),
        .o_pbyte   (pbyte_next)
    );

    // Runs that exist and hit a patched universe; last when none follows.
    always_comb begin
        run_last = 1'b1;
        for (int j = 0; j < MAX_RUNS; j++) begin
            run_mask[j] = r_found[j] && (RUN_IDX_W'(j) < r_nruns);
        end
        for (int j = 0; j < MAX_RUNS; j++) begin
            if ((RUN_IDX_W'(j) > r_k) && run_mask[j]) begin
                run_last = 1'b0;
            end
        end
    end

    // Run count, saturated pixel positions, slot field and output load.
    always_comb begin
        end_pos  = 14'(r_off) + 14'(r_rem) - 14'd1;
        pix_sum  = 17'(r_pix_base) + 17'(r_pix);
        pix_sat  = (pix_sum > 17'(PIX_CAP)) ? FPIX_W'(PIX_CAP) : pix_sum[FPIX_W-1:0];
        base_sum = 17'(r_pix_base) + 17'(r_pcount);
        base_sat = (base_sum > 17'(PIX_CAP)) ? FPIX_W'(PIX_CAP) : base_sum[FPIX_W-1:0];
        slot_ext = {{SLOTO_W{1'b0}}, r_slot[r_k]};
        out_free = !r_out_vld || i_ready;
        emit     = (r_state == ST_EMIT) && (r_rem != '0) && out_free && run_mask[r_k];
    end

    // Sequencer, run state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pix_base <= '0;
            r_found    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_mode == MODE_CLEAR)) begin
                        r_pix_base <= '0;
                    end
                    if (accept && (i_mode == MODE_MAP)) begin
                        r_uid    <= i_universe_id;
                        r_off    <= i_start_address;
                        r_rem    <= total;
                        r_pbyte  <= '0;
                        r_pix    <= '0;
                        r_cpp    <= cpp_eff;
                        r_pcount <= i_pixel_count;
                        r_k      <= '0;
                        r_found  <= '0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Newest slots come first, so the first hit per run wins.
                    if (tbl_stat.hit && !r_found[tbl_stat.run_idx]) begin
                        r_found[tbl_stat.run_idx] <= 1'b1;
                        r_slot[tbl_stat.run_idx]  <= tbl_slot;
                    end
                    if (!tbl_stat.busy) begin
                        r_nruns <= (r_rem == '0) ? '0 :
                                   RUN_IDX_W'(end_pos[13:9]) + RUN_IDX_W'(1);
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_rem == '0) begin
                        r_pix_base <= base_sat;
                        r_state    <= ST_IDLE;
                    end else if (out_free) begin
                        if (emit) begin
                            r_o_slot  <= slot_ext[SLOTO_W-1:0];
                            r_o_off   <= r_off;
                            r_o_run   <= run_len;
                            r_o_cpp   <= r_cpp;
                            r_o_pix   <= pix_sat;
                            r_o_pbyte <= r_pbyte;
                            r_o_last  <= run_last;
                        end
                        r_off   <= '0;
                        r_rem   <= rem_next;
                        r_pix   <= r_pix + TOTAL_W'(pix_inc);
                        r_pbyte <= pbyte_next;
                        r_k     <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_out_vld;
    assign o_universe_slot    = r_o_slot;
    assign o_universe_offset  = r_o_off;
    assign o_run_bytes        = r_o_run;
    assign o_bytes_per_pixel  = r_o_cpp;
    assign o_first_pixel      = r_o_pix;
    assign o_first_pixel_byte = r_o_pbyte;
    assign o_last             = r_o_last;

endmodule
`default_nettype wire

>>> src/dfus_table.sv
// Patch table of universe ids with a one-entry-per-cycle match scan.
`timescale 1ns / 1ps
`default_nettype none
module dfus_table
    import dfus_pkg::*;
#(
    parameter int MAX_UNIVERSES = MAX_UNIVERSES_DEF,
    parameter int SLOT_W        = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_cmd          i_cmd,
    input  wire logic [ID_W-1:0]   i_id,
    input  wire logic [ID_W-1:0]   i_base_id,
    output t_tbl_stat              o_stat,
    output logic      [SLOT_W-1:0] o_slot
);

    localparam int FILL_W = $clog2(MAX_UNIVERSES + 1);

    logic [ID_W-1:0]   r_mem [MAX_UNIVERSES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_left;
    logic [SLOT_W-1:0] r_addr;
    logic              r_active;
    logic              r_rd_vld;
    logic [ID_W-1:0]   r_rd_data;
    logic [SLOT_W-1:0] r_rd_slot;

    logic [FILL_W-1:0] fill_m1;
    logic              room;
    logic [ID_W:0]     diff;

    assign fill_m1 = r_fill - 1'b1;
    assign room    = (r_fill < FILL_W'(MAX_UNIVERSES));

    // Memory write on append, registered read during the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && room) begin
            r_mem[r_fill[SLOT_W-1:0]] <= i_id;
        end
        r_rd_data <= r_mem[r_addr];
        r_rd_slot <= r_addr;
    end

    // Fill count and scan control; entries below the fill count are valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_left   <= '0;
            r_addr   <= '0;
            r_active <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_active;
            if (i_cmd.clear) begin
                r_fill <= '0;
            end else if (i_cmd.append && room) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.scan) begin
                r_active <= (r_fill != '0);
                r_addr   <= fill_m1[SLOT_W-1:0];
                r_left   <= r_fill;
            end else if (r_active) begin
                r_addr <= r_addr - 1'b1;
                r_left <= r_left - 1'b1;
                if (r_left == FILL_W'(1)) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // Shared compare: distance of the stored id from the fixture's first universe.
    assign diff = {1'b0, r_rd_data} - {1'b0, i_base_id};

    always_comb begin
        o_stat.busy    = r_active | r_rd_vld;
        o_stat.hit     = r_rd_vld && (diff < (ID_W + 1)'(MAX_RUNS));
        o_stat.run_idx = diff[RUN_IDX_W-1:0];
        o_slot         = r_rd_slot;
    end

endmodule
`default_nettype wire

>>> src/dfus_run.sv
// One run step: run length, remaining bytes and pixel position advance.
`timescale 1ns / 1ps
`default_nettype none
module dfus_run
    import dfus_pkg::*;
(
    input  wire logic [ADDR_W-1:0]  i_off,
    input  wire logic [TOTAL_W-1:0] i_rem,
    input  wire logic [PBYTE_W-1:0] i_pbyte,
    input  wire logic [CPP_W-1:0]   i_cpp,
    output logic      [RUNB_W-1:0]  o_run,
    output logic      [TOTAL_W-1:0] o_rem,
    output logic      [RUNB_W-1:0]  o_pix_inc,
    output logic      [PBYTE_W-1:0] o_pbyte
);

    logic [RUNB_W-1:0] space;
    logic [RUNB_W-1:0] sum;
    logic [20:0]       prod3;
    logic [RUNB_W-1:0] q3;
    logic [RUNB_W-1:0] r3;

    // The run ends at the universe boundary or at the fixture's last byte.
    always_comb begin
        space = RUNB_W'(UNIVERSE_BYTES) - {1'b0, i_off};
        if (TOTAL_W'(space) > i_rem) begin
            o_run = i_rem[RUNB_W-1:0];
        end else begin
            o_run = space;
        end
        o_rem = i_rem - TOTAL_W'(o_run);
    end

    // Split the byte position into whole pixels and a byte within the pixel.
    // Division by three uses a reciprocal that is exact below 1536.
    always_comb begin
        sum   = RUNB_W'(i_pbyte) + o_run;
        prod3 = 21'(sum) * 21'd683;
        q3    = prod3[20:11];
        r3    = sum - RUNB_W'(q3 * 3);
        unique case (i_cpp)
            3'd1: begin
                o_pix_inc = sum;
                o_pbyte   = '0;
            end
            3'd2: begin
                o_pix_inc = sum >> 1;
                o_pbyte   = {1'b0, sum[0]};
            end
            3'd3: begin
                o_pix_inc = q3;
                o_pbyte   = r3[PBYTE_W-1:0];
            end
            default: begin
                o_pix_inc = sum >> 2;
                o_pbyte   = sum[1:0];
            end
        endcase
    end

endmodule
`default_nettype wire

>>> test/tb_dmx_fixture_universe_splitter_unit.sv
// Self-checking testbench for the DMX universe splitter.
`timescale 1ns / 1ps
module tb_dmx_fixture_universe_splitter_unit;
    import dfus_pkg::*;

    // Mode code that the block has to ignore.
    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int PIXEL_CAP    = (MAX_PIXELS_DEF - 1 > 65535) ? 65535 : MAX_PIXELS_DEF - 1;
    localparam int TARGET_ITEMS = 360;
    localparam int CALM_ITEMS   = 60;

    // One copy instruction as it leaves the block.
    typedef struct packed {
        logic [SLOTO_W-1:0] slot;
        logic [ADDR_W-1:0]  offset;
        logic [RUNB_W-1:0]  run_bytes;
        logic [CPP_W-1:0]   bpp;
        logic [FPIX_W-1:0]  first_pixel;
        logic [PBYTE_W-1:0] pixel_byte;
        logic               last;
    } t_copy_instr;

    // Mirror of the patch table and pixel index, and the copy instructions still owed.
    class t_plan_checker;
        logic [ID_W-1:0] patch_ids [MAX_UNIVERSES_DEF];
        bit              patch_used [MAX_UNIVERSES_DEF];
        int              patch_fill;
        int              pixel_base;
        t_copy_instr     pending_copies [$];
        int              errors;

        function new();
            patch_fill = 0;
            pixel_base = 0;
            errors     = 0;
            foreach (patch_used[i]) patch_used[i] = 1'b0;
        endfunction

        function int saturate_pixel(int v);
            return (v > PIXEL_CAP) ? PIXEL_CAP : v;
        endfunction

        function int pending();
            return pending_copies.size();
        endfunction

        // Append one instruction to the owed list.
        function void owe_copy(t_copy_instr c);
            pending_copies.insert(pending_copies.size(), c);
        endfunction

        // Update the mirror for one accepted command and queue the copies it causes.
        function void take_command(logic [1:0] mode, logic [ID_W-1:0] uid_in,
                                   logic [ADDR_W-1:0] addr, logic [PCNT_W-1:0] pcnt,
                                   logic [CPP_W-1:0] cpp_in);
            int          cpp, remaining, offset, pix, pbyte, run, slot;
            logic [15:0] uid;
            bit          have;
            t_copy_instr held;
            case (mode)
                MODE_CLEAR: begin
                    foreach (patch_used[i]) patch_used[i] = 1'b0;
                    patch_fill = 0;
                    pixel_base = 0;
                end
                MODE_APPEND: begin
                    // A full table drops further appends.
                    if (patch_fill < MAX_UNIVERSES_DEF) begin
                        patch_ids[patch_fill]  = uid_in;
                        patch_used[patch_fill] = 1'b1;
                        patch_fill++;
                    end
                end
                MODE_MAP: begin
                    cpp       = (cpp_in == 0) ? 1 : ((cpp_in > 4) ? 4 : int'(cpp_in));
                    remaining = int'(pcnt) * cpp;
                    offset    = int'(addr);
                    pix       = 0;
                    pbyte     = 0;
                    uid       = {1'b0, uid_in};
                    have      = 1'b0;
                    while (remaining > 0) begin
                        run = UNIVERSE_BYTES - offset;
                        if (run > remaining) run = remaining;
                        // The newest slot holding the id wins.
                        slot = -1;
                        for (int i = patch_fill - 1; i >= 0 && slot < 0; i--) begin
                            if (patch_used[i] && {1'b0, patch_ids[i]} == uid) slot = i;
                        end
                        if (slot >= 0) begin
                            if (have) owe_copy(held);
                            held.slot        = SLOTO_W'(slot);
                            held.offset      = ADDR_W'(offset);
                            held.run_bytes   = RUNB_W'(run);
                            held.bpp         = CPP_W'(cpp);
                            held.first_pixel = FPIX_W'(saturate_pixel(pixel_base + pix));
                            held.pixel_byte  = PBYTE_W'(pbyte);
                            held.last        = 1'b0;
                            have             = 1'b1;
                        end
                        // Skipped runs still move the pixel position.
                        uid       = uid + 16'd1;
                        offset    = 0;
                        remaining = remaining - run;
                        pix       = pix + (pbyte + run) / cpp;
                        pbyte     = (pbyte + run) % cpp;
                    end
                    if (have) begin
                        held.last = 1'b1;
                        owe_copy(held);
                    end
                    pixel_base = saturate_pixel(pixel_base + int'(pcnt));
                end
                default: ;
            endcase
        endfunction

        // Compare one received copy instruction with the oldest one owed.
        function void check_copy(t_copy_instr got);
            t_copy_instr want;
            if (pending_copies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display({"Unexpected copy: slot=%0d off=%0d bytes=%0d bpp=%0d",
                              " pix=%0d pb=%0d last=%0b"},
                             got.slot, got.offset, got.run_bytes, got.bpp, got.first_pixel,
                             got.pixel_byte, got.last);
                return;
            end
            want = pending_copies.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("Copy mismatch at %0t", $realtime);
                    $display({"  expected slot=%0d off=%0d bytes=%0d bpp=%0d",
                              " pix=%0d pb=%0d last=%0b"},
                             want.slot, want.offset, want.run_bytes, want.bpp, want.first_pixel,
                             want.pixel_byte, want.last);
                    $display({"  actual   slot=%0d off=%0d bytes=%0d bpp=%0d",
                              " pix=%0d pb=%0d last=%0b"},
                             got.slot, got.offset, got.run_bytes, got.bpp, got.first_pixel,
                             got.pixel_byte, got.last);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_mode;
    logic [ID_W-1:0]    i_universe_id;
    logic [ADDR_W-1:0]  i_start_address;
    logic [PCNT_W-1:0]  i_pixel_count;
    logic [CPP_W-1:0]   i_channels_per_pixel;
    logic               o_valid;
    logic               i_ready;
    logic [SLOTO_W-1:0] o_universe_slot;
    logic [ADDR_W-1:0]  o_universe_offset;
    logic [RUNB_W-1:0]  o_run_bytes;
    logic [CPP_W-1:0]   o_bytes_per_pixel;
    logic [FPIX_W-1:0]  o_first_pixel;
    logic [PBYTE_W-1:0] o_first_pixel_byte;
    logic               o_last;

    t_plan_checker     plan_check;
    int                item_count = 0;
    bit                idle_on    = 1'b1;
    int                ready_hold = 0;

    dmx_fixture_universe_splitter_unit u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_mode               (i_mode),
        .i_universe_id        (i_universe_id),
        .i_start_address      (i_start_address),
        .i_pixel_count        (i_pixel_count),
        .i_channels_per_pixel (i_channels_per_pixel),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_universe_slot      (o_universe_slot),
        .o_universe_offset    (o_universe_offset),
        .o_run_bytes          (o_run_bytes),
        .o_bytes_per_pixel    (o_bytes_per_pixel),
        .o_first_pixel        (o_first_pixel),
        .o_first_pixel_byte   (o_first_pixel_byte),
        .o_last               (o_last)
    );

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output side: check every transfer and, while idle_on is set, stall in short random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            plan_check.check_copy(t_copy_instr'{o_universe_slot, o_universe_offset,
                                                o_run_bytes, o_bytes_per_pixel,
                                                o_first_pixel, o_first_pixel_byte,
                                                o_last});
        end
        if (ready_hold > 0) begin
            i_ready    <= 1'b0;
            ready_hold = ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_ready    <= 1'b0;
            ready_hold = int'($urandom_range(0, 2));
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Present one command, hold it until the transfer, then note it.
    task automatic send_cmd(input logic [1:0] mode, input logic [ID_W-1:0] uid,
                            input logic [ADDR_W-1:0] addr, input logic [PCNT_W-1:0] pcnt,
                            input logic [CPP_W-1:0] cpp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_mode               <= mode;
        i_universe_id        <= uid;
        i_start_address      <= addr;
        i_pixel_count        <= pcnt;
        i_channels_per_pixel <= cpp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        plan_check.take_command(mode, uid, addr, pcnt, cpp);
        if (mode != MODE_IGNORED) item_count++;
    endtask

    // Patch a block of mostly consecutive ids, with the odd repeat.
    task automatic add_universes(input int base_id, input int count);
        logic [ID_W-1:0] uid;
        for (int k = 0; k < count; k++) begin
            uid = ID_W'(base_id + k);
            if ($urandom_range(0, 5) == 0) uid = ID_W'(base_id + int'($urandom_range(0, k)));
            send_cmd(MODE_APPEND, uid, ADDR_W'($urandom), PCNT_W'($urandom), CPP_W'($urandom));
        end
    endtask

    // A fixture that starts on or near the patched block of ids.
    task automatic send_random_fixture(input int base_id, input int span);
        logic [ID_W-1:0]   uid;
        logic [ADDR_W-1:0] addr;
        logic [PCNT_W-1:0] pcnt;
        uid = ID_W'(base_id + int'($urandom_range(0, span + 2)) - 2);
        case ($urandom_range(0, 3))
            0:       addr = '0;
            1:       addr = '1;
            2:       addr = ADDR_W'(512 - int'($urandom_range(1, 16)));
            default: addr = ADDR_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       pcnt = '0;
            1:       pcnt = '1;
            2, 3:    pcnt = PCNT_W'($urandom);
            default: pcnt = PCNT_W'($urandom_range(1, 200));
        endcase
        send_cmd(MODE_MAP, uid, addr, pcnt, CPP_W'($urandom_range(0, 7)));
    endtask

    // Stimulus and end of run.
    initial begin
        int base, n_ids, kind;
        bit first_phase;
        plan_check           = new();
        i_rst_n              <= 1'b0;
        i_valid              <= 1'b0;
        i_ready              <= 1'b0;
        i_mode               <= MODE_CLEAR;
        i_universe_id        <= '0;
        i_start_address      <= '0;
        i_pixel_count        <= '0;
        i_channels_per_pixel <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, ignored mode, clear.
        send_cmd(MODE_MAP, 15'd0, 9'd0, 10'd4, 3'd1);
        send_cmd(MODE_IGNORED, 15'd100, 9'd7, 10'd9, 3'd2);
        send_cmd(MODE_CLEAR, '1, '1, '1, '1);
        // Patch ids at both ends of the range and a repeated id.
        send_cmd(MODE_APPEND, 15'd0, '0, '0, '0);
        send_cmd(MODE_APPEND, 15'd1, '0, '0, '0);
        send_cmd(MODE_APPEND, 15'd32767, '0, '0, '0);
        send_cmd(MODE_APPEND, 15'd100, '0, '0, '0);
        send_cmd(MODE_APPEND, 15'd101, '0, '0, '0);
        send_cmd(MODE_APPEND, 15'd100, '0, '0, '0);
        // Fixtures: channel count clamping, longest span, id past the top,
        // split pixels, zero pixels, skipped first run and absent universe.
        send_cmd(MODE_MAP, 15'd100, 9'd0, 10'd1, 3'd0);
        send_cmd(MODE_MAP, 15'd100, 9'd511, 10'd1023, 3'd7);
        send_cmd(MODE_MAP, 15'd32767, 9'd500, 10'd100, 3'd3);
        send_cmd(MODE_MAP, 15'd0, 9'd510, 10'd3, 3'd5);
        send_cmd(MODE_MAP, 15'd0, 9'd0, 10'd0, 3'd4);
        send_cmd(MODE_MAP, 15'd99, 9'd300, 10'd200, 3'd2);
        send_cmd(MODE_MAP, 15'd5, 9'd20, 10'd50, 3'd4);
        send_cmd(MODE_MAP, 15'd101, 9'd0, 10'd1023, 3'd4);
        send_cmd(MODE_MAP, 15'd1, 9'd255, 10'd128, 3'd6);
        // A clear drops every patched universe.
        send_cmd(MODE_CLEAR, '0, '0, '0, '0);
        send_cmd(MODE_MAP, 15'd0, 9'd0, 10'd10, 3'd3);

        // Random phases; the first one drives the pixel index into saturation.
        first_phase = 1'b1;
        while (item_count < TARGET_ITEMS) begin
            idle_on = (item_count < TARGET_ITEMS - CALM_ITEMS);
            if (first_phase || $urandom_range(0, 3) != 0)
                send_cmd(MODE_CLEAR, ID_W'($urandom), ADDR_W'($urandom),
                         PCNT_W'($urandom), CPP_W'($urandom));
            case ($urandom_range(0, 7))
                0:       base = 0;
                1, 2:    base = 32767 - int'($urandom_range(0, 8));
                default: base = int'($urandom_range(0, 32767));
            endcase
            if (first_phase) begin
                add_universes(base, 3);
                repeat (70) begin
                    send_cmd(MODE_MAP, ID_W'(base + int'($urandom_range(0, 2))),
                             ADDR_W'($urandom),
                             PCNT_W'(1023 - int'($urandom_range(0, 30))),
                             CPP_W'($urandom_range(1, 4)));
                end
            end else begin
                kind  = int'($urandom_range(0, 5));
                n_ids = (kind == 0) ? int'($urandom_range(64, 70)) : int'($urandom_range(1, 12));
                add_universes(base, n_ids);
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 9) == 0)
                        send_cmd(2'($urandom_range(0, 3)), ID_W'($urandom), ADDR_W'($urandom),
                                 PCNT_W'($urandom), CPP_W'($urandom));
                    else
                        send_random_fixture(base, n_ids);
                end
            end
            first_phase = 1'b0;
        end
        i_valid <= 1'b0;

        // Drain, then give the block time to show any stray output.
        while (plan_check.pending() != 0) @(posedge i_clk);
        repeat (MAX_UNIVERSES_DEF + MAX_RUNS + 20) @(posedge i_clk);
        if (plan_check.errors == 0 && plan_check.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
